// ----- src/xrr_pkg.sv -----
// Shared types and constants of the ranged xoshiro256** random unit.
package xrr_pkg;

  // Item kinds
  localparam logic [1:0] KIND_RAW    = 2'd0;
  localparam logic [1:0] KIND_RANGED = 2'd1;
  localparam logic [1:0] KIND_LOAD   = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  // Generator constants
  localparam int unsigned SCR_ROT    = 7;
  localparam int unsigned ADV_SHIFT  = 17;
  localparam int unsigned ADV_ROT    = 45;

  // Remainder loop: one quotient bit per cycle over the 63-bit dividend
  localparam int unsigned DIV_STEPS  = 63;
  localparam int unsigned CNT_W      = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic [1:0]         word_select;
    logic [63:0]        seed_word;
  } in_item_t;

  typedef struct packed {
    logic [63:0]        raw_value;
    logic signed [31:0] ranged_value;
    logic               range_error;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic mul;
    logic draw;
    logic div_step;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] kind;
    logic       div_last;
  } status_t;

endpackage

// ----- src/xrr_ctrl.sv -----
// Controller state machine of the ranged xoshiro256** random unit.
module xrr_ctrl
  import xrr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MUL,
    ST_DRAW,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Decode commands from the current state
  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.mul      = (state_q == ST_MUL);
    cmd_o.draw     = (state_q == ST_DRAW);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.finish   = (state_q == ST_FIN) && out_free;
  end

  // Drop the output valid flag on a transfer, raise it when a result finishes
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end
  end

  // Hold state and the output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          if (status_i.kind == KIND_RAW || status_i.kind == KIND_RANGED) begin
            state_q <= ST_MUL;
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_MUL: begin
          state_q <= ST_DRAW;
        end
        ST_DRAW: begin
          if (status_i.kind == KIND_RANGED) begin
            state_q <= ST_DIV;
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_DIV: begin
          if (status_i.div_last) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_finish_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_o)
    else $error("finished result not shown");
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.capture, cmd_o.mul, cmd_o.draw, cmd_o.div_step, cmd_o.finish}))
    else $error("more than one datapath command");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !cmd_o.finish)
    else $error("result overwritten while stalled");
`endif

endmodule

// ----- src/xrr_datapath.sv -----
// Datapath of the ranged xoshiro256** random unit: state words, scrambler, remainder loop.
module xrr_datapath
  import xrr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_data_i,
  input  cmd_t      cmd_i,
  output status_t   status_o,
  output out_item_t out_data_o
);

  in_item_t         item_q;
  logic [63:0]      words_q [4];
  logic [63:0]      p5_q;
  logic [63:0]      raw_q;
  logic [62:0]      div_q;
  logic [32:0]      rem_q;
  logic [32:0]      rem_d;
  logic [32:0]      span_q;
  logic [32:0]      span_d;
  logic [CNT_W-1:0] cnt_q;
  logic             err_q;
  out_item_t        out_q;
  out_item_t        out_d;

  logic [63:0] p5_d;
  logic [63:0] rot;
  logic [63:0] raw_d;
  logic [63:0] adv_t;
  logic [63:0] n0;
  logic [63:0] n1;
  logic [63:0] n2;
  logic [63:0] n3;
  logic [33:0] rem_sh;
  logic        rem_ge;
  logic        err_d;

  // Scrambler: w1*5, rotate, *9 as shift-adds, with w1*5 registered before the rotate
  assign p5_d  = words_q[1] + {words_q[1][61:0], 2'b00};
  assign rot   = {p5_q[63-SCR_ROT:0], p5_q[63:64-SCR_ROT]};
  assign raw_d = rot + {rot[60:0], 3'b000};

  // Linear state advance
  always_comb begin
    adv_t = words_q[1] << ADV_SHIFT;
    n2    = words_q[2] ^ words_q[0];
    n3    = words_q[3] ^ words_q[1];
    n1    = words_q[1] ^ n2;
    n0    = words_q[0] ^ n3;
    n2    = n2 ^ adv_t;
    n3    = {n3[63-ADV_ROT:0], n3[63:64-ADV_ROT]};
  end

  // Range span and inverted-range check
  assign span_d = 33'($signed({item_q.range_high[31], item_q.range_high})
                - $signed({item_q.range_low[31], item_q.range_low})) + 33'd1;
  assign err_d  = (item_q.range_high < item_q.range_low);

  // One restoring remainder step
  assign rem_sh = {rem_q, div_q[62]};
  assign rem_ge = (rem_sh >= {1'b0, span_q});
  assign rem_d  = rem_ge ? 33'(rem_sh - {1'b0, span_q}) : rem_sh[32:0];

  // Form the result of the finishing item
  always_comb begin
    out_d = '0;
    case (item_q.kind)
      KIND_RAW: begin
        out_d.raw_value = raw_q;
      end
      KIND_RANGED: begin
        out_d.raw_value    = raw_q;
        out_d.range_error  = err_q;
        out_d.ranged_value = err_q ? item_q.range_low
                                   : item_q.range_low + $signed(rem_q[31:0]);
      end
      default: begin
        out_d = '0;
      end
    endcase
  end

  // Hold the generator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        words_q[i] <= '0;
      end
    end else if (cmd_i.draw) begin
      words_q[0] <= n0;
      words_q[1] <= n1;
      words_q[2] <= n2;
      words_q[3] <= n3;
    end else if (cmd_i.finish && item_q.kind == KIND_LOAD) begin
      words_q[item_q.word_select] <= item_q.seed_word;
    end
  end

  // Capture the item, draw, iterate the remainder and hold the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
    if (cmd_i.mul) begin
      p5_q <= p5_d;
    end
    if (cmd_i.draw) begin
      raw_q  <= raw_d;
      div_q  <= raw_d[63] ? raw_d[63:1] : raw_d[62:0];
      rem_q  <= '0;
      span_q <= span_d;
      err_q  <= err_d;
      cnt_q  <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_d;
      div_q <= {div_q[61:0], 1'b0};
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.finish) begin
      out_q <= out_d;
    end
  end

  assign status_o.kind     = item_q.kind;
  assign status_o.div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));
  assign out_data_o        = out_q;

`ifndef NO_ASSERTIONS
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_step && !err_q) |-> (rem_q < span_q))
    else $error("remainder out of range");
  a_other_kinds_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && item_q.kind != KIND_RANGED) |=>
      (out_q.ranged_value == '0 && !out_q.range_error))
    else $error("ranged fields set for non-ranged item");
`endif

endmodule

// ----- src/xoshiro_random_ranged_unit.sv -----
// Top level of the ranged xoshiro256** random unit.
//
//   channel  direction  handshake                payload
//   in       to unit    in_valid_i / in_stall_o    in_data_i  (in_item_t)
//   out      from unit  out_valid_o / out_stall_i  out_data_o (out_item_t)
//
// Load and unused items go from dispatch to finish; raw draws add the multiply
// and draw states, and ranged draws also run the 63-step restoring remainder loop.
// One item is in work at a time; the output register lets the next item
// enter while a result still waits to be taken.
// Reset clears the four state words to zero; they must be loaded before use.
// A stalled output holds its result and the finishing item waits for it.
module xoshiro_random_ranged_unit
  import xrr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  cmd_t    cmd;
  status_t status;

  xrr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  xrr_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule
